>>> rtl/core/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// shared types, sizes and codes for the circular deque
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic signed [31:0] word_t;
  typedef logic [1:0]        req_type_t;
  typedef logic [1:0]        status_t;

  localparam idx_t LAST_IDX  = idx_t'(DEPTH - 1);
  localparam cnt_t FULL_CNT  = cnt_t'(DEPTH);

  localparam req_type_t REQ_PUSH_REAR  = 2'd0;
  localparam req_type_t REQ_PUSH_FRONT = 2'd1;
  localparam req_type_t REQ_POP_REAR   = 2'd2;
  localparam req_type_t REQ_POP_FRONT  = 2'd3;

  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

endpackage

>>> rtl/core/cdq_if.sv
// ----------------------------------------------------------------------------
// cdq_req_if / cdq_rsp_if
// valid/ready channels for deque requests and results
// ----------------------------------------------------------------------------
interface cdq_req_if;
  logic                 valid;
  logic                 ready;
  cdq_pkg::req_type_t   req_type;
  cdq_pkg::word_t       push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface cdq_rsp_if;
  logic                 valid;
  logic                 ready;
  cdq_pkg::status_t     status;
  cdq_pkg::word_t       pop_value;
  cdq_pkg::cnt_t        item_count;

  modport source (output valid, output status, output pop_value, output item_count,
                  input ready);
  modport sink   (input valid, input status, input pop_value, input item_count,
                  output ready);
endinterface

>>> rtl/core/circular_deque_top.sv
// ----------------------------------------------------------------------------
// circular_deque_top
// double-ended queue in a circular single-port-read memory
// result: registered, shows in the cycle after the request transaction
// throughput: one request per cycle unless rsp stalls; pop data comes from
//   the memory's registered read port, pointers and count update at accept
// reset: pointers, count and output valid clear; memory contents are not reset
// ----------------------------------------------------------------------------
module circular_deque_top (
  input  logic      clk,
  input  logic      rst,
  cdq_req_if.sink   req,
  cdq_rsp_if.source rsp
);

  cdq_pkg::idx_t head, head_next;
  cdq_pkg::idx_t tail, tail_next;
  cdq_pkg::cnt_t occupancy, occupancy_next;

  cdq_pkg::word_t mem [cdq_pkg::DEPTH];
  cdq_pkg::word_t rd_data;

  logic             wr_en, rd_en;
  cdq_pkg::idx_t    wr_addr, rd_addr;
  cdq_pkg::status_t status_next;

  logic             out_valid;
  cdq_pkg::status_t out_status;
  cdq_pkg::cnt_t    out_count;
  logic             out_pop;

  logic in_fire;
  logic is_push;

  function automatic cdq_pkg::cnt_t cnt_t_one();
    return cdq_pkg::cnt_t'(1);
  endfunction

  assign req.ready = !out_valid || rsp.ready;
  assign in_fire   = req.valid && req.ready;
  assign is_push   = (req.req_type == cdq_pkg::REQ_PUSH_REAR) ||
                     (req.req_type == cdq_pkg::REQ_PUSH_FRONT);

  always_comb begin
    head_next      = head;
    tail_next      = tail;
    occupancy_next = occupancy;
    status_next    = cdq_pkg::ST_DONE;
    wr_en          = 1'b0;
    wr_addr        = '0;
    rd_en          = 1'b0;
    rd_addr        = tail;
    if (is_push) begin
      if (occupancy == cdq_pkg::FULL_CNT) begin
        status_next = cdq_pkg::ST_FULL;
      end else begin
        wr_en          = 1'b1;
        occupancy_next = occupancy + cnt_t_one();
        if (occupancy == '0) begin
          head_next = '0;
          tail_next = '0;
          wr_addr   = '0;
        end else if (req.req_type == cdq_pkg::REQ_PUSH_REAR) begin
          tail_next = (tail == cdq_pkg::LAST_IDX) ? '0 : tail + 1'b1;
          wr_addr   = tail_next;
        end else begin
          head_next = (head == '0) ? cdq_pkg::LAST_IDX : head - 1'b1;
          wr_addr   = head_next;
        end
      end
    end else begin
      if (occupancy == '0) begin
        status_next = cdq_pkg::ST_EMPTY;
      end else begin
        rd_en          = 1'b1;
        occupancy_next = occupancy - cnt_t_one();
        if (req.req_type == cdq_pkg::REQ_POP_REAR) begin
          rd_addr   = tail;
          tail_next = (tail == '0) ? cdq_pkg::LAST_IDX : tail - 1'b1;
        end else begin
          rd_addr   = head;
          head_next = (head == cdq_pkg::LAST_IDX) ? '0 : head + 1'b1;
        end
      end
    end
  end

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (in_fire && wr_en) begin
      mem[wr_addr] <= req.push_value;
    end
    if (in_fire && rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      occupancy <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        head      <= head_next;
        tail      <= tail_next;
        occupancy <= occupancy_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, held while the transaction waits
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_status <= status_next;
      out_count  <= occupancy_next;
      out_pop    <= rd_en;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.item_count = out_count;
  assign rsp.pop_value  = out_pop ? rd_data : '0;

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= cdq_pkg::FULL_CNT)
    else $error("occupancy above depth");

  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (occupancy == cdq_pkg::cnt_t'(1)) |-> (head == tail))
    else $error("head and tail differ with one item held");

  a_full_refuse: assert property (@(posedge clk) disable iff (rst)
    (in_fire && is_push && occupancy == cdq_pkg::FULL_CNT)
      |=> (rsp.status == cdq_pkg::ST_FULL && occupancy == cdq_pkg::FULL_CNT))
    else $error("push to full store not refused");

  a_empty_refuse: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !is_push && occupancy == '0)
      |=> (rsp.status == cdq_pkg::ST_EMPTY && rsp.pop_value == '0 && occupancy == '0))
    else $error("pop from empty store not refused");

  a_count_match: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (rsp.valid && rsp.item_count == occupancy))
    else $error("result count differs from occupancy");
`endif

endmodule

>>> dv/circular_deque_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circular_deque_top_tb
// Checks the circular deque against a behavioral deque model. A short
// directed sequence hits empty and full refusals and index wrap at both ends.
// A long random sequence then drifts between filling and draining, under
// bursty requests and a result channel that stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module circular_deque_top_tb;

  localparam int             RANDOM_REQS = 1050;
  localparam int             CYCLE_LIMIT = 200000;
  localparam cdq_pkg::word_t WORD_MAX    = 32'sh7fffffff;
  localparam cdq_pkg::word_t WORD_MIN    = 32'sh80000000;

  typedef struct packed {
    cdq_pkg::status_t status;
    cdq_pkg::word_t   pop_value;
    cdq_pkg::cnt_t    item_count;
  } deque_result_t;

  class deque_scoreboard;
    cdq_pkg::word_t slot_mem [cdq_pkg::DEPTH];
    cdq_pkg::idx_t  front_idx = '0;
    cdq_pkg::idx_t  rear_idx = '0;
    cdq_pkg::cnt_t  held = '0;
    deque_result_t  due_results [$];
    int             mismatches = 0;

    function void note_request(cdq_pkg::req_type_t kind, cdq_pkg::word_t value);
      deque_result_t res;
      res.status = cdq_pkg::ST_DONE;
      res.pop_value = '0;
      if (kind == cdq_pkg::REQ_PUSH_REAR || kind == cdq_pkg::REQ_PUSH_FRONT) begin
        if (held == cdq_pkg::FULL_CNT) begin
          res.status = cdq_pkg::ST_FULL;
        end else begin
          if (held == '0) begin
            front_idx = '0;
            rear_idx = '0;
            slot_mem[0] = value;
          end else if (kind == cdq_pkg::REQ_PUSH_REAR) begin
            rear_idx = (rear_idx == cdq_pkg::LAST_IDX) ? cdq_pkg::idx_t'(0)
                                                       : cdq_pkg::idx_t'(rear_idx + 1'b1);
            slot_mem[rear_idx] = value;
          end else begin
            front_idx = (front_idx == '0) ? cdq_pkg::LAST_IDX
                                          : cdq_pkg::idx_t'(front_idx - 1'b1);
            slot_mem[front_idx] = value;
          end
          held = held + 1'b1;
        end
      end else if (held == '0) begin
        res.status = cdq_pkg::ST_EMPTY;
      end else begin
        if (kind == cdq_pkg::REQ_POP_REAR) begin
          res.pop_value = slot_mem[rear_idx];
          rear_idx = (rear_idx == '0) ? cdq_pkg::LAST_IDX
                                      : cdq_pkg::idx_t'(rear_idx - 1'b1);
        end else begin
          res.pop_value = slot_mem[front_idx];
          front_idx = (front_idx == cdq_pkg::LAST_IDX) ? cdq_pkg::idx_t'(0)
                                                       : cdq_pkg::idx_t'(front_idx + 1'b1);
        end
        held = held - 1'b1;
      end
      res.item_count = held;
      due_results.push_back(res);
    endfunction

    function void check_result(cdq_pkg::status_t status, cdq_pkg::word_t pop_value,
                               cdq_pkg::cnt_t item_count);
      deque_result_t want;
      if (due_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: status %0d pop_value %0d item_count %0d",
                   status, pop_value, item_count);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      if (want.status !== status || want.pop_value !== pop_value ||
          want.item_count !== item_count) begin
        if (mismatches < 10)
          $display("mismatch: status %0d/%0d pop_value %0d/%0d item_count %0d/%0d",
                   want.status, status, want.pop_value, pop_value,
                   want.item_count, item_count);
        mismatches++;
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  cdq_req_if req_if ();
  cdq_rsp_if rsp_if ();

  deque_scoreboard sb = new();

  circular_deque_top dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic cdq_pkg::word_t pick_value();
    case ($urandom_range(0, 7))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return '0;
      3: return -1;
      default: return cdq_pkg::word_t'($urandom);
    endcase
  endfunction

  task automatic send_request(cdq_pkg::req_type_t kind, cdq_pkg::word_t value);
    req_if.valid <= 1'b1;
    req_if.req_type <= kind;
    req_if.push_value <= value;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(kind, value);
  endtask

  task automatic pause_requests(int cycles);
    req_if.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_results_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    int                 burst_left;
    int                 push_pct;
    int                 gap;
    cdq_pkg::req_type_t kind;
    rst <= 1'b1;
    req_if.valid <= 1'b0;
    req_if.req_type <= cdq_pkg::REQ_PUSH_REAR;
    req_if.push_value <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty refusals, wrap at both ends, push into empty store
    send_request(cdq_pkg::REQ_POP_REAR, WORD_MAX);
    send_request(cdq_pkg::REQ_POP_FRONT, WORD_MIN);
    send_request(cdq_pkg::REQ_PUSH_REAR, WORD_MAX);
    send_request(cdq_pkg::REQ_PUSH_FRONT, WORD_MIN);
    send_request(cdq_pkg::REQ_POP_FRONT, '0);
    send_request(cdq_pkg::REQ_POP_REAR, '0);
    send_request(cdq_pkg::REQ_PUSH_REAR, '0);
    send_request(cdq_pkg::REQ_POP_REAR, -1);
    // fill to full, then a refused push
    for (int i = 0; i < cdq_pkg::DEPTH; i++)
      send_request(i[0] ? cdq_pkg::REQ_PUSH_FRONT : cdq_pkg::REQ_PUSH_REAR, pick_value());
    send_request(cdq_pkg::REQ_PUSH_REAR, -1);

    burst_left = 0;
    push_pct = 50;
    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (i == RANDOM_REQS / 2) begin
        wait_results_drained();
        burst_left = 0;
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        case ($urandom_range(0, 3))
          0: push_pct = 15;
          1: push_pct = 50;
          2: push_pct = 85;
          default: push_pct = 97;
        endcase
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0)
          pause_requests(gap);
      end
      burst_left--;
      if ($urandom_range(1, 100) <= push_pct)
        kind = $urandom_range(0, 1) ? cdq_pkg::REQ_PUSH_FRONT : cdq_pkg::REQ_PUSH_REAR;
      else
        kind = $urandom_range(0, 1) ? cdq_pkg::REQ_POP_FRONT : cdq_pkg::REQ_POP_REAR;
      send_request(kind, pick_value());
    end

    wait_results_drained();
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // result side: check each transaction, stall in modes of random length
  initial begin
    int mode;
    int mode_left;
    mode = 0;
    mode_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_if.valid && rsp_if.ready)
        sb.check_result(rsp_if.status, rsp_if.pop_value, rsp_if.item_count);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(8, 80);
      end
      mode_left--;
      case (mode)
        0: rsp_if.ready <= 1'b1;
        1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
        2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
        default: rsp_if.ready <= (mode_left % 3 != 0);
      endcase
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

endmodule

>>> files.f
rtl/core/cdq_pkg.sv
rtl/core/cdq_if.sv
rtl/core/circular_deque_top.sv
dv/circular_deque_top_tb.sv
